### hw/rtl/rpt_pkg.sv
// Shared types and codes for the rectangle placement table.
`default_nettype none
package rpt_pkg;

    localparam int unsigned COORD_W = 18;
    localparam int unsigned END_W   = COORD_W + 1;
    localparam int unsigned POWER_W = 16;
    localparam int unsigned INDEX_W = 8;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned OCNT_W  = 5;
    localparam int unsigned STAT_W  = 2;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_rect;

    typedef enum logic {
        REQ_PLACE  = 1'b0,
        REQ_REMOVE = 1'b1
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_OVERLAP = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_APPEND,
        S_SHIFT,
        S_RESULT
    } t_state;

endpackage
`default_nettype wire

### hw/rtl/rpt_store.sv
// Rectangle storage memory: one write port, one registered read port.
`default_nettype none
module rpt_store
    import rpt_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rect         i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_rect              o_rdata
);

    t_rect r_mem [DEPTH];
    t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/rpt_overlap.sv
// Shared compare unit: strict overlap of two rectangles on both axes.
`default_nettype none
module rpt_overlap
    import rpt_pkg::*;
(
    input  wire t_rect i_entry,
    input  wire t_rect i_cand,
    output logic       o_hit
);

    logic [END_W-1:0] w_ex_end, w_ey_end, w_cx_end, w_cy_end;
    logic [END_W-1:0] w_x_lo, w_x_hi, w_y_lo, w_y_hi;

    always_comb begin
        w_ex_end = END_W'(i_entry.x) + END_W'(i_entry.w);
        w_ey_end = END_W'(i_entry.y) + END_W'(i_entry.h);
        w_cx_end = END_W'(i_cand.x) + END_W'(i_cand.w);
        w_cy_end = END_W'(i_cand.y) + END_W'(i_cand.h);
        w_x_lo = (i_entry.x > i_cand.x) ? END_W'(i_entry.x) : END_W'(i_cand.x);
        w_y_lo = (i_entry.y > i_cand.y) ? END_W'(i_entry.y) : END_W'(i_cand.y);
        w_x_hi = (w_ex_end < w_cx_end) ? w_ex_end : w_cx_end;
        w_y_hi = (w_ey_end < w_cy_end) ? w_ey_end : w_cy_end;
        // touching edges give hi == lo and do not count
        o_hit = (w_x_hi > w_x_lo) && (w_y_hi > w_y_lo);
    end

endmodule
`default_nettype wire

### hw/rtl/rectangle_placement_table.sv
// Top level: request sequencer, counters and output register of the placement table.
//
// Holds up to MAX_ENTRIES rectangles in an internal memory read one entry per cycle.
// A place request walks the held entries through one shared overlap compare unit:
// an overlap ends the walk early, an empty table skips it and a full table gives
// its result with no walk. A remove request moves each later entry down one place,
// one entry per cycle; a bad index gives its result with no shift. The block takes one
// item at a time and is ready again as soon as the result is loaded; a result not
// yet taken holds the next one back. The memory needs no clearing after reset:
// only entries below the held count are used.
`default_nettype none
module rectangle_placement_table
    import rpt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // rect_x, rect_y, rect_width, rect_height, rect_power, remove_index
    input  wire logic [95:0] i_s_tdata,
    // req_type
    input  wire logic        i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // status, entry_count, power_total, zero pad
    output logic [39:0]      o_m_tdata
);

    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [SUM_W-1:0]  r_power, n_power;
    logic [CW-1:0]     r_ridx, n_ridx;
    logic              r_pend, n_pend;
    logic [AW-1:0]     r_wadr, n_wadr;
    t_status           r_status, n_status;

    t_req              r_req_type;
    t_rect             r_rect;
    logic [POWER_W-1:0] r_rpow;
    logic [INDEX_W-1:0] r_rm_idx;

    logic              r_ovalid, n_ovalid;
    logic              w_load;
    t_status           r_o_status;
    logic [OCNT_W-1:0] r_o_count;
    logic [SUM_W-1:0]  r_o_power;

    logic              w_accept;
    logic              w_hit;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_rect             mem_wdata;
    t_rect             mem_rdata;
    logic [INDEX_W-1:0] w_count_ix;
    logic [SUM_W:0]    w_sum;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_count_ix = INDEX_W'(r_count);
    assign w_sum      = (SUM_W + 1)'(r_power) + (SUM_W + 1)'(r_rpow);

    rpt_store #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_ridx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    rpt_overlap u_overlap (
        .i_entry (mem_rdata),
        .i_cand  (r_rect),
        .o_hit   (w_hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_power  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_power  <= n_power;
            r_pend   <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_wadr   <= n_wadr;
        r_status <= n_status;
        if (w_accept) begin
            r_req_type <= t_req'(i_s_tuser);
            r_rect     <= t_rect'(i_s_tdata[71:0]);
            r_rpow     <= i_s_tdata[87:72];
            r_rm_idx   <= i_s_tdata[95:88];
        end
        if (w_load) begin
            r_o_status <= r_status;
            r_o_count  <= OCNT_W'(r_count);
            r_o_power  <= r_power;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_power   = r_power;
        n_ridx    = r_ridx;
        n_pend    = r_pend;
        n_wadr    = r_wadr;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_wadr;
        mem_wdata = mem_rdata;
        w_load    = 1'b0;
        n_ovalid  = r_ovalid && !i_m_tready;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_pend = 1'b0;
                if (r_req_type == REQ_PLACE) begin
                    n_ridx = '0;
                    if (r_count >= CW'(MAX_ENTRIES)) begin
                        n_status = ST_FULL;
                        n_state  = S_RESULT;
                    end else if (r_count == '0) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    if (r_rm_idx >= w_count_ix) begin
                        n_status = ST_RANGE;
                        n_state  = S_RESULT;
                    end else begin
                        n_ridx  = CW'(r_rm_idx) + CW'(1);
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SCAN: begin
                // read one entry per cycle, compare the one read last cycle
                if (r_pend && w_hit) begin
                    n_status = ST_OVERLAP;
                    n_state  = S_RESULT;
                end else if (r_ridx == r_count) begin
                    n_state = S_APPEND;
                end else begin
                    n_ridx = r_ridx + CW'(1);
                    n_pend = 1'b1;
                end
            end
            S_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = r_count[AW-1:0];
                mem_wdata = r_rect;
                n_count   = r_count + CW'(1);
                n_power   = w_sum[SUM_W] ? '1 : w_sum[SUM_W-1:0];
                n_status  = ST_OK;
                n_state   = S_RESULT;
            end
            S_SHIFT: begin
                // write the entry read last cycle one place down
                mem_we = r_pend;
                if (r_ridx == r_count) begin
                    n_count  = r_count - CW'(1);
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    n_state  = S_RESULT;
                end else begin
                    n_wadr = AW'(r_ridx - CW'(1));
                    n_ridx = r_ridx + CW'(1);
                    n_pend = 1'b1;
                end
            end
            S_RESULT: begin
                if (!r_ovalid || i_m_tready) begin
                    w_load   = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {1'b0, r_o_power, r_o_count, r_o_status};

endmodule
`default_nettype wire

### hw/rtl/rpt_checker.sv
// Port-level assertions for the rectangle placement table, bound to the top level.
`default_nettype none
module rpt_checker
    import rpt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 16
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [95:0] i_s_tdata,
    input wire logic        i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata
);

    logic w_unused;
    assign w_unused = ^{i_s_tdata, i_s_tuser};

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("accepted a second item while busy");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (MAX_ENTRIES > 31) || (o_m_tdata[6:2] <= 5'(MAX_ENTRIES)))
        else $error("entry count above table size");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == ST_FULL) |-> o_m_tdata[6:2] == 5'(MAX_ENTRIES))
        else $error("full status with table not full");

endmodule

bind rectangle_placement_table rpt_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_rpt_checker (.*);
`default_nettype wire
